/* hw/rtl/assert_macros.svh */
// Assertion helpers for the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge, off while reset is active.
`define ASSERT_CLK(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// Check that a condition never holds on a rising clock edge.
`define ASSERT_NEVER(label, clk, rst_n, cond, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) else $error(msg);

`endif

/* hw/rtl/swis_pkg.sv */
package swis_pkg;

	// Widths: ports, internal datapath, multiplier operand magnitude
	localparam int IN_W  = 32;
	localparam int OUT_W = 31;
	localparam int CNT_W = 8;
	localparam int VAL_W = 40;
	localparam int MAG_W = 33;
	localparam int FRAC  = 30;
	localparam int TERMS = 24;

	typedef logic signed [VAL_W-1:0] val_t;
	typedef logic [MAG_W-1:0]        mag_t;

	localparam val_t ONE_FX    = 40'sd1073741824;
	localparam val_t EIGHTH_FX = 40'sd268435456;
	localparam val_t SAT_FX    = 40'sd2147483647;
	// pi rounded to 30 fraction bits, and twice that value
	localparam mag_t PI_FX     = 33'd3373259426;
	localparam mag_t TWO_PI_FX = 33'd6746518852;

	typedef enum logic [2:0] {
		STATUS_OK          = 3'd0,
		STATUS_BAD_OPTIONS = 3'd1,
		STATUS_DOMAIN      = 3'd2,
		STATUS_NONMONO     = 3'd3,
		STATUS_LIMIT       = 3'd4
	} status_t;

	typedef enum logic [2:0] {
		CFG_EPSILON   = 3'd0,
		CFG_DELTA     = 3'd1,
		CFG_TOLERANCE = 3'd2,
		CFG_MARGIN    = 3'd3,
		CFG_MAX_ITER  = 3'd4
	} cfg_idx_t;

	// Taylor divisors n(n+1): sine terms first, then cosine terms
	localparam logic [9:0] TAYLOR_DIV [TERMS] = '{
		10'd6, 10'd20, 10'd42, 10'd72, 10'd110, 10'd156,
		10'd210, 10'd272, 10'd342, 10'd420, 10'd506, 10'd600,
		10'd2, 10'd12, 10'd30, 10'd56, 10'd90, 10'd132,
		10'd182, 10'd240, 10'd306, 10'd380, 10'd462, 10'd552
	};

	// Reciprocal shift: 32 + floor(log2(divisor))
	localparam logic [5:0] TAYLOR_SHIFT [TERMS] = '{
		6'd34, 6'd36, 6'd37, 6'd38, 6'd38, 6'd39,
		6'd39, 6'd40, 6'd40, 6'd40, 6'd40, 6'd41,
		6'd33, 6'd35, 6'd36, 6'd37, 6'd38, 6'd39,
		6'd39, 6'd39, 6'd40, 6'd40, 6'd40, 6'd41
	};

	// Reciprocal floor(2^shift / divisor), one below the true quotient at most
	localparam mag_t TAYLOR_RECIP [TERMS] = '{
		33'((65'd1 << 34) / 65'd6),   33'((65'd1 << 36) / 65'd20),
		33'((65'd1 << 37) / 65'd42),  33'((65'd1 << 38) / 65'd72),
		33'((65'd1 << 38) / 65'd110), 33'((65'd1 << 39) / 65'd156),
		33'((65'd1 << 39) / 65'd210), 33'((65'd1 << 40) / 65'd272),
		33'((65'd1 << 40) / 65'd342), 33'((65'd1 << 40) / 65'd420),
		33'((65'd1 << 40) / 65'd506), 33'((65'd1 << 41) / 65'd600),
		33'((65'd1 << 33) / 65'd2),   33'((65'd1 << 35) / 65'd12),
		33'((65'd1 << 36) / 65'd30),  33'((65'd1 << 37) / 65'd56),
		33'((65'd1 << 38) / 65'd90),  33'((65'd1 << 39) / 65'd132),
		33'((65'd1 << 39) / 65'd182), 33'((65'd1 << 39) / 65'd240),
		33'((65'd1 << 40) / 65'd306), 33'((65'd1 << 40) / 65'd380),
		33'((65'd1 << 40) / 65'd462), 33'((65'd1 << 41) / 65'd552)
	};

	// Magnitude of a datapath value, cut to multiplier operand width
	function automatic mag_t mag_of(input val_t v);
		val_t a;
		a = (v < 0) ? -v : v;
		return a[MAG_W-1:0];
	endfunction

endpackage

/* hw/rtl/sine_warp_inverse_solver_unit.sv */
// Channel   Signals                                     Handshake
// request   start, target                               start & !busy
// result    done, solution, abs_residual,               done strobe, one cycle
//           iteration_count, converged, used_bisection, status
// config    cfg_valid, cfg_ready, cfg_index, cfg_data   cfg_valid & cfg_ready
//
// One request at a time; busy stays high from acceptance through the done cycle.
// done follows S_CHECK on an option or domain failure, and S_MUL and S_BOUND on a failed bound.
// A sine/cosine pass runs its Taylor terms on the shared 33x33 multiplier; a Newton step
// is two passes, six products and a restoring divide, which a quotient of two or more skips.
// The last step of a request stops after the residual.
// arst_n clears the sequencer and loads the register defaults; results cannot stall.
`include "assert_macros.svh"

module sine_warp_inverse_solver_unit import swis_pkg::*; (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    start,
	output logic                    busy,
	input  logic signed [IN_W-1:0]  target,
	input  logic                    cfg_valid,
	output logic                    cfg_ready,
	input  logic [2:0]              cfg_index,
	input  logic [IN_W-1:0]         cfg_data,
	output logic                    done,
	output logic [OUT_W-1:0]        solution,
	output logic [OUT_W-1:0]        abs_residual,
	output logic [CNT_W-1:0]        iteration_count,
	output logic                    converged,
	output logic                    used_bisection,
	output logic [2:0]              status
);

	typedef enum logic [20:0] {
		S_IDLE     = 21'h000001,
		S_CHECK    = 21'h000002,
		S_BOUND    = 21'h000004,
		S_EVAL     = 21'h000008,
		S_MUL      = 21'h000010,
		S_SC_XR    = 21'h000020,
		S_SC_X2    = 21'h000040,
		S_TERM_CHK = 21'h000080,
		S_TERM_Q   = 21'h000100,
		S_TERM_C   = 21'h000200,
		S_TERM_ADD = 21'h000400,
		S_SC_END   = 21'h000800,
		S_F2       = 21'h001000,
		S_F3       = 21'h002000,
		S_SL2      = 21'h004000,
		S_SL3      = 21'h008000,
		S_SL4      = 21'h010000,
		S_SL5      = 21'h020000,
		S_DIV      = 21'h040000,
		S_DIV_END  = 21'h080000,
		S_DONE     = 21'h100000
	} state_t;

	state_t state_q, ret_q;

	// Configuration registers
	logic signed [IN_W-1:0] eps_q, del_q;
	logic [OUT_W-1:0]       tol_q, margin_q;
	logic [CNT_W-1:0]       maxit_q;

	// Solver state
	val_t y_q, t_q, lower_q, upper_q, r_q, acc_q;
	val_t xr_q, x2_q, term_q, sum_q, ss_q, s1_q, c1_q, s2_q, c2_q;
	logic pass_q, ser_q, tneg_q, neg_q, dneg_q, bis_q;
	logic [1:0] quad_q;
	logic [3:0] k_q;
	logic [CNT_W-1:0] it_q;
	logic [4:0] cnt_q;
	mag_t op_a_q, op_b_q, mm_q;
	logic [2*MAG_W-1:0] prod_q;
	logic [31:0] qe_q, quo_q;
	logic [VAL_W-1:0] rem_q, den_q;

	// Result registers
	logic [OUT_W-1:0] sol_q, res_q;
	logic [CNT_W-1:0] cnt_out_q;
	logic conv_q, bisf_q;
	status_t status_q;

	// Rounded signed product
	logic [2*MAG_W:0] rnd_full;
	val_t rnd_mag, mres;
	assign rnd_full = {1'b0, prod_q} + ((2*MAG_W+1)'(1) << (FRAC - 1));
	assign rnd_mag  = val_t'({3'b000, rnd_full[2*MAG_W:FRAC]});
	assign mres     = neg_q ? -rnd_mag : rnd_mag;

	// Angle reduction: quadrant and offset in [-1/4, 1/4) half-turns
	val_t u_ang, x_ang;
	logic [31:0] v_q8;
	assign u_ang = pass_q ? (t_q + t_q) : t_q;
	assign v_q8  = {1'b0, u_ang[30:0]} + 32'(EIGHTH_FX);
	assign x_ang = val_t'({11'b0, v_q8[28:0]}) - EIGHTH_FX;

	// Taylor term division by reciprocal with one correction
	logic [4:0] tidx;
	logic [2*MAG_W-1:0] qe_full;
	mag_t rem_t, q_corr, div_d;
	val_t new_term;
	assign tidx     = ser_q ? (5'd11 + {1'b0, k_q}) : ({1'b0, k_q} - 5'd1);
	assign div_d    = mag_t'(TAYLOR_DIV[tidx]);
	assign qe_full  = prod_q >> TAYLOR_SHIFT[tidx];
	assign rem_t    = mm_q - prod_q[MAG_W-1:0];
	assign q_corr   = mag_t'(qe_q) + ((rem_t >= div_d) ? mag_t'(1) : mag_t'(0));
	assign new_term = tneg_q ? -val_t'(q_corr) : val_t'(q_corr);

	// Quadrant mapping of sine and cosine sums
	val_t s_map, c_map;
	always_comb begin
		case (quad_q)
			2'd0: begin s_map = ss_q;   c_map = sum_q;  end
			2'd1: begin s_map = sum_q;  c_map = -ss_q;  end
			2'd2: begin s_map = -ss_q;  c_map = -sum_q; end
			2'd3: begin s_map = -sum_q; c_map = ss_q;   end
			default: begin s_map = ss_q; c_map = sum_q; end
		endcase
	end

	// Residual, slope and bound
	val_t r_new, r_abs, slope_new, bound, mid, qs, cand;
	logic r_conv;
	logic [OUT_W-1:0] r_sat;
	mag_t wsum;
	assign r_new     = acc_q + mres - y_q;
	assign r_abs     = (r_new < 0) ? -r_new : r_new;
	assign r_conv    = r_abs <= val_t'({9'b0, tol_q});
	assign r_sat     = (r_abs > SAT_FX) ? '1 : r_abs[OUT_W-1:0];
	assign slope_new = acc_q + mres;
	assign wsum      = mag_of(val_t'(eps_q)) + (mag_of(val_t'(del_q)) << 1);
	assign bound     = ONE_FX - mres;
	assign mid       = (lower_q + upper_q) >>> 1;
	assign qs        = dneg_q ? -val_t'({8'b0, quo_q}) : val_t'({8'b0, quo_q});
	assign cand      = t_q - qs;

	// Divider operands and one restoring step
	logic [VAL_W-1:0] d_num, d_den, rem_sub;
	logic d_big, d_ge;
	assign d_num   = (r_q < 0) ? -r_q : r_q;
	assign d_den   = (slope_new < 0) ? -slope_new : slope_new;
	assign d_big   = {1'b0, d_num} >= {d_den, 1'b0};
	assign d_ge    = rem_q >= den_q;
	assign rem_sub = d_ge ? (rem_q - den_q) : rem_q;

	assign busy      = state_q != S_IDLE;
	assign done      = state_q == S_DONE;
	assign cfg_ready = 1'b1;

	assign solution        = sol_q;
	assign abs_residual    = res_q;
	assign iteration_count = cnt_out_q;
	assign converged       = conv_q;
	assign used_bisection  = bisf_q;
	assign status          = status_q;

	// Write configuration registers; drop unknown indexes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			eps_q    <= '0;
			del_q    <= '0;
			tol_q    <= 31'd1024;
			margin_q <= '0;
			maxit_q  <= 8'd32;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				CFG_EPSILON:   eps_q    <= cfg_data;
				CFG_DELTA:     del_q    <= cfg_data;
				CFG_TOLERANCE: tol_q    <= cfg_data[OUT_W-1:0];
				CFG_MARGIN:    margin_q <= cfg_data[OUT_W-1:0];
				CFG_MAX_ITER:  maxit_q  <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// Shared multiplier
	always_ff @(posedge clk) begin
		prod_q <= op_a_q * op_b_q;
	end

	// Sequencer and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ret_q   <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (start) begin
						y_q       <= val_t'(target);
						t_q       <= val_t'(target);
						lower_q   <= '0;
						upper_q   <= ONE_FX;
						it_q      <= '0;
						bis_q     <= 1'b0;
						pass_q    <= 1'b0;
						sol_q     <= '0;
						res_q     <= '0;
						cnt_out_q <= '0;
						conv_q    <= 1'b0;
						bisf_q    <= 1'b0;
						state_q   <= S_CHECK;
					end
				end
				S_CHECK: begin
					if (tol_q == '0 || maxit_q == '0) begin
						status_q <= STATUS_BAD_OPTIONS;
						state_q  <= S_DONE;
					end else if (y_q < 0 || y_q > ONE_FX) begin
						status_q <= STATUS_DOMAIN;
						state_q  <= S_DONE;
					end else begin
						op_a_q  <= PI_FX;
						op_b_q  <= wsum;
						neg_q   <= 1'b0;
						ret_q   <= S_BOUND;
						state_q <= S_MUL;
					end
				end
				S_BOUND: begin
					if (bound > val_t'({9'b0, margin_q})) begin
						state_q <= S_EVAL;
					end else begin
						status_q <= STATUS_NONMONO;
						state_q  <= S_DONE;
					end
				end
				S_MUL: begin
					state_q <= ret_q;
				end
				// Start a sine/cosine pass: x times pi
				S_EVAL: begin
					quad_q  <= v_q8[30:29];
					op_a_q  <= mag_of(x_ang);
					op_b_q  <= PI_FX;
					neg_q   <= x_ang < 0;
					ret_q   <= S_SC_XR;
					state_q <= S_MUL;
				end
				S_SC_XR: begin
					xr_q    <= mres;
					op_a_q  <= mag_of(mres);
					op_b_q  <= mag_of(mres);
					neg_q   <= 1'b0;
					ret_q   <= S_SC_X2;
					state_q <= S_MUL;
				end
				S_SC_X2: begin
					x2_q    <= mres;
					term_q  <= xr_q;
					sum_q   <= xr_q;
					k_q     <= 4'd1;
					ser_q   <= 1'b0;
					state_q <= S_TERM_CHK;
				end
				// Stop the series on a zero term or after twelve terms
				S_TERM_CHK: begin
					if (term_q == 0 || k_q == 4'd13) begin
						state_q <= S_SC_END;
					end else begin
						op_a_q  <= mag_of(term_q);
						op_b_q  <= mag_of(x2_q);
						neg_q   <= term_q < 0;
						ret_q   <= S_TERM_Q;
						state_q <= S_MUL;
					end
				end
				S_TERM_Q: begin
					mm_q    <= rnd_mag[MAG_W-1:0];
					tneg_q  <= !neg_q;
					op_a_q  <= rnd_mag[MAG_W-1:0];
					op_b_q  <= TAYLOR_RECIP[tidx];
					ret_q   <= S_TERM_C;
					state_q <= S_MUL;
				end
				S_TERM_C: begin
					qe_q    <= qe_full[31:0];
					op_a_q  <= mag_t'(qe_full[31:0]);
					op_b_q  <= div_d;
					ret_q   <= S_TERM_ADD;
					state_q <= S_MUL;
				end
				S_TERM_ADD: begin
					term_q  <= new_term;
					sum_q   <= sum_q + new_term;
					k_q     <= k_q + 4'd1;
					state_q <= S_TERM_CHK;
				end
				// Switch to the cosine series, or store the pass result
				S_SC_END: begin
					if (!ser_q) begin
						ss_q    <= sum_q;
						term_q  <= ONE_FX;
						sum_q   <= ONE_FX;
						k_q     <= 4'd1;
						ser_q   <= 1'b1;
						state_q <= S_TERM_CHK;
					end else if (!pass_q) begin
						s1_q    <= s_map;
						c1_q    <= c_map;
						pass_q  <= 1'b1;
						state_q <= S_EVAL;
					end else begin
						s2_q    <= s_map;
						c2_q    <= c_map;
						op_a_q  <= mag_of(val_t'(eps_q));
						op_b_q  <= mag_of(s1_q);
						neg_q   <= (eps_q < 0) ^ (s1_q < 0);
						ret_q   <= S_F2;
						state_q <= S_MUL;
					end
				end
				S_F2: begin
					acc_q   <= t_q + mres;
					op_a_q  <= mag_of(val_t'(del_q));
					op_b_q  <= mag_of(s2_q);
					neg_q   <= (del_q < 0) ^ (s2_q < 0);
					ret_q   <= S_F3;
					state_q <= S_MUL;
				end
				// Finish on convergence or at the limit, else narrow the bracket
				S_F3: begin
					r_q <= r_new;
					if (r_conv || it_q == maxit_q) begin
						sol_q     <= t_q[OUT_W-1:0];
						res_q     <= r_sat;
						cnt_out_q <= it_q;
						conv_q    <= r_conv;
						bisf_q    <= bis_q;
						status_q  <= r_conv ? STATUS_OK : STATUS_LIMIT;
						state_q   <= S_DONE;
					end else begin
						if (r_new < 0) begin
							lower_q <= t_q;
						end else begin
							upper_q <= t_q;
						end
						op_a_q  <= PI_FX;
						op_b_q  <= mag_of(val_t'(eps_q));
						neg_q   <= eps_q < 0;
						ret_q   <= S_SL2;
						state_q <= S_MUL;
					end
				end
				S_SL2: begin
					op_a_q  <= mag_of(mres);
					op_b_q  <= mag_of(c1_q);
					neg_q   <= (mres < 0) ^ (c1_q < 0);
					ret_q   <= S_SL3;
					state_q <= S_MUL;
				end
				S_SL3: begin
					acc_q   <= ONE_FX + mres;
					op_a_q  <= TWO_PI_FX;
					op_b_q  <= mag_of(val_t'(del_q));
					neg_q   <= del_q < 0;
					ret_q   <= S_SL4;
					state_q <= S_MUL;
				end
				S_SL4: begin
					op_a_q  <= mag_of(mres);
					op_b_q  <= mag_of(c2_q);
					neg_q   <= (mres < 0) ^ (c2_q < 0);
					ret_q   <= S_SL5;
					state_q <= S_MUL;
				end
				// Bisect on zero slope, else start the Newton quotient
				S_SL5: begin
					if (slope_new == 0) begin
						t_q     <= mid;
						bis_q   <= 1'b1;
						it_q    <= it_q + 8'd1;
						pass_q  <= 1'b0;
						state_q <= S_EVAL;
					end else begin
						dneg_q <= (r_q < 0) ^ (slope_new < 0);
						den_q  <= d_den;
						rem_q  <= d_num;
						quo_q  <= '0;
						cnt_q  <= '0;
						if (d_big) begin
							quo_q   <= 32'h8000_0000;
							state_q <= S_DIV_END;
						end else begin
							state_q <= S_DIV;
						end
					end
				end
				S_DIV: begin
					rem_q <= rem_sub << 1;
					quo_q <= {quo_q[30:0], d_ge};
					cnt_q <= cnt_q + 5'd1;
					if (cnt_q == 5'd30) begin
						state_q <= S_DIV_END;
					end
				end
				// Take the Newton candidate if strictly inside the bracket
				S_DIV_END: begin
					if (cand > lower_q && cand < upper_q) begin
						t_q <= cand;
					end else begin
						t_q   <= mid;
						bis_q <= 1'b1;
					end
					it_q    <= it_q + 8'd1;
					pass_q  <= 1'b0;
					state_q <= S_EVAL;
				end
				S_DONE: begin
					state_q <= S_IDLE;
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	`ASSERT_CLK(a_done_pulse, clk, arst_n, done |=> !done, "done held longer than one cycle")
	`ASSERT_CLK(a_accept_busy, clk, arst_n, start && !busy |=> busy, "accepted request not busy")
	`ASSERT_CLK(a_bracket, clk, arst_n, busy |-> lower_q <= upper_q, "bracket inverted")
	`ASSERT_NEVER(a_conv_status, clk, arst_n, done && converged && status != STATUS_OK, "converged with bad status")
	`ASSERT_NEVER(a_sol_range, clk, arst_n, done && solution > 31'd1073741824, "solution above one")

endmodule

/* tb/sine_warp_inverse_solver_unit_test.sv */
`timescale 1ns / 100ps

module sine_warp_inverse_solver_unit_test;
	import swis_pkg::*;

	localparam longint ONE_Q        = 64'sd1 << 30;
	localparam longint MAG_LIMIT    = 64'sh1FFF_FFFF_FFFF_FFFF;
	localparam longint NARROW_LIMIT = 64'sh7FFF_FFFF;
	localparam logic [63:0] PI_Q62  = 64'hC90FDAA22168C235;
	localparam longint PI_Q30       = longint'((PI_Q62 + (64'd1 << 31)) >> 32);
	localparam logic [2:0] CFG_SPARE_LO = 3'd5;
	localparam logic [2:0] CFG_SPARE_HI = 3'd7;
	localparam int IDLE_LIMIT = 400000;

	typedef struct {
		logic [OUT_W-1:0] solution;
		logic [OUT_W-1:0] abs_residual;
		logic [CNT_W-1:0] iteration_count;
		logic             converged;
		logic             used_bisection;
		status_t          status;
	} solve_t;

	logic clk = 1'b0;
	logic arst_n;
	logic start;
	logic busy;
	logic signed [IN_W-1:0] target;
	logic cfg_valid;
	logic cfg_ready;
	logic [2:0] cfg_index;
	logic [IN_W-1:0] cfg_data;
	logic done;
	logic [OUT_W-1:0] solution;
	logic [OUT_W-1:0] abs_residual;
	logic [CNT_W-1:0] iteration_count;
	logic converged;
	logic used_bisection;
	logic [2:0] status;

	// Shadow copy of the option registers
	logic [31:0] epsilon_q;
	logic [31:0] delta_q;
	logic [30:0] tolerance_q;
	logic [30:0] margin_q;
	logic [7:0]  iter_limit_q;

	solve_t pending_solves[$];
	int mismatches = 0;
	int idle_cycles = 0;

	sine_warp_inverse_solver_unit i_dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .target(target),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
		.cfg_data(cfg_data), .done(done), .solution(solution),
		.abs_residual(abs_residual), .iteration_count(iteration_count),
		.converged(converged), .used_bisection(used_bisection), .status(status)
	);

	always #5 clk = ~clk;

	function automatic logic [63:0] mag64(longint v);
		return (v < 0) ? 64'(-v) : 64'(v);
	endfunction

	// Rounded Q30 product, saturating magnitude
	function automatic longint fx_mul(longint a, longint b);
		logic [127:0] p;
		logic [63:0] m;
		longint r;
		p = {64'd0, mag64(a)} * {64'd0, mag64(b)};
		p = p + (128'd1 << 29);
		if (p[127:94] != 0)
			m = MAG_LIMIT;
		else
			m = p[93:30];
		if (m > MAG_LIMIT)
			m = MAG_LIMIT;
		r = longint'(m);
		return ((a < 0) != (b < 0)) ? -r : r;
	endfunction

	// sin and cos of pi*u by quadrant fold and Taylor series
	function automatic void sin_cos_half_turn(longint u, output longint s, output longint c);
		longint v, q, x, xr, x2, st, ss, ct, cs;
		v = u & ((64'sd1 << 31) - 1);
		q = (v + (64'sd1 << 28)) >>> 29;
		x = v - q * (64'sd1 << 29);
		xr = fx_mul(x, PI_Q30);
		x2 = fx_mul(xr, xr);
		st = xr; ss = xr; ct = ONE_Q; cs = ONE_Q;
		for (longint k = 1; k <= 12 && st != 0; k++) begin
			st = -fx_mul(st, x2) / ((2 * k) * (2 * k + 1));
			ss += st;
		end
		for (longint k = 1; k <= 12 && ct != 0; k++) begin
			ct = -fx_mul(ct, x2) / ((2 * k - 1) * (2 * k));
			cs += ct;
		end
		case (q & 3)
			0: begin s = ss; c = cs; end
			1: begin s = cs; c = -ss; end
			2: begin s = -ss; c = -cs; end
			default: begin s = -cs; c = ss; end
		endcase
	endfunction

	function automatic longint warp_value(longint t, longint e, longint d);
		longint s1, c1, s2, c2;
		sin_cos_half_turn(t, s1, c1);
		sin_cos_half_turn(t + t, s2, c2);
		return t + fx_mul(e, s1) + fx_mul(d, s2);
	endfunction

	function automatic longint warp_slope(longint t, longint e, longint d);
		longint s1, c1, s2, c2;
		sin_cos_half_turn(t, s1, c1);
		sin_cos_half_turn(t + t, s2, c2);
		return ONE_Q + fx_mul(fx_mul(PI_Q30, e), c1)
			+ fx_mul(fx_mul(PI_Q30 + PI_Q30, d), c2);
	endfunction

	// Truncating Q30 quotient, magnitude capped at two
	function automatic longint fx_div(longint r, longint s);
		logic [63:0] a, b, q;
		logic [127:0] n;
		a = mag64(r);
		b = mag64(s);
		if (a >= 2 * b) begin
			q = 64'd1 << 31;
		end else begin
			n = {64'd0, a} << 30;
			q = 64'(n / {64'd0, b});
		end
		return ((r < 0) != (s < 0)) ? -longint'(q) : longint'(q);
	endfunction

	function automatic logic [OUT_W-1:0] clip_residual(longint v);
		logic [63:0] m;
		m = mag64(v);
		return (m > NARROW_LIMIT) ? OUT_W'(NARROW_LIMIT) : OUT_W'(m);
	endfunction

	function automatic solve_t predict_solve(logic [31:0] y_bits);
		solve_t o;
		longint y, e, d, tol, lo, hi, t, r, sl, cand, bound;
		int it;
		logic bis;
		y = longint'($signed(y_bits));
		e = longint'($signed(epsilon_q));
		d = longint'($signed(delta_q));
		tol = longint'(tolerance_q);
		lo = 0; hi = ONE_Q; t = y; bis = 1'b0;
		o = '{default: '0, status: STATUS_OK};
		if (tol == 0 || iter_limit_q == 0) begin
			o.status = STATUS_BAD_OPTIONS;
			return o;
		end
		if (y < 0 || y > ONE_Q) begin
			o.status = STATUS_DOMAIN;
			return o;
		end
		bound = ONE_Q - fx_mul(PI_Q30, longint'(mag64(e) + 2 * mag64(d)));
		if (!(bound > longint'(margin_q))) begin
			o.status = STATUS_NONMONO;
			return o;
		end
		for (it = 0; it < iter_limit_q; it++) begin
			r = warp_value(t, e, d) - y;
			if (longint'(mag64(r)) <= tol) begin
				o.solution = OUT_W'(t);
				o.abs_residual = clip_residual(r);
				o.iteration_count = CNT_W'(it);
				o.converged = 1'b1;
				o.used_bisection = bis;
				return o;
			end
			if (r < 0)
				lo = t;
			else
				hi = t;
			sl = warp_slope(t, e, d);
			if (sl != 0) begin
				cand = t - fx_div(r, sl);
				if (cand > lo && cand < hi) begin
					t = cand;
					continue;
				end
			end
			t = (lo + hi) >>> 1;
			bis = 1'b1;
		end
		r = warp_value(t, e, d) - y;
		o.solution = OUT_W'(t);
		o.abs_residual = clip_residual(r);
		o.iteration_count = iter_limit_q;
		o.converged = (longint'(mag64(r)) <= tol);
		o.status = o.converged ? STATUS_OK : STATUS_LIMIT;
		o.used_bisection = bis;
		return o;
	endfunction

	// Compare each result strobe against the oldest prediction
	always @(posedge clk) begin
		solve_t w;
		if (arst_n && done) begin
			if (pending_solves.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("unexpected result: solution %0d status %0d", solution, status);
			end else begin
				w = pending_solves.pop_front();
				if (solution !== w.solution || abs_residual !== w.abs_residual ||
						iteration_count !== w.iteration_count || converged !== w.converged ||
						used_bisection !== w.used_bisection || status !== w.status) begin
					mismatches++;
					if (mismatches <= 10)
						$display("mismatch: exp t=%0d res=%0d it=%0d cv=%0d bis=%0d st=%0d / got t=%0d res=%0d it=%0d cv=%0d bis=%0d st=%0d",
							w.solution, w.abs_residual, w.iteration_count, w.converged,
							w.used_bisection, w.status, solution, abs_residual,
							iteration_count, converged, used_bisection, status);
				end
			end
		end
	end

	// Abort when nothing moves for too long
	always @(posedge clk) begin
		if ((start && !busy) || done || (cfg_valid && cfg_ready))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
		if (idle_cycles >= IDLE_LIMIT) begin
			$display("== FAIL ==");
			$finish;
		end
	end

	// Send one request, then drop start once it is taken
	task automatic send_target(logic [31:0] y, int gap);
		repeat (gap) @(posedge clk);
		@(posedge clk);
		start <= 1'b1;
		target <= y;
		do @(posedge clk); while (busy);
		pending_solves.push_back(predict_solve(y));
		start <= 1'b0;
	endtask

	task automatic drain_results();
		@(posedge clk);
		while (pending_solves.size() != 0 || busy) @(posedge clk);
	endtask

	task automatic write_option(logic [2:0] idx, logic [31:0] value);
		drain_results();
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (cfg_idx_t'(idx))
			CFG_EPSILON:   epsilon_q = value;
			CFG_DELTA:     delta_q = value;
			CFG_TOLERANCE: tolerance_q = value[30:0];
			CFG_MARGIN:    margin_q = value[30:0];
			CFG_MAX_ITER:  iter_limit_q = value[7:0];
			default: ;
		endcase
	endtask

	task automatic set_options(logic [31:0] e, logic [31:0] d, logic [31:0] tol,
			logic [31:0] marg, logic [31:0] lim);
		write_option(CFG_EPSILON, e);
		write_option(CFG_DELTA, d);
		write_option(CFG_TOLERANCE, tol);
		write_option(CFG_MARGIN, marg);
		write_option(CFG_MAX_ITER, lim);
	endtask

	function automatic int pick_gap();
		return ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 6);
	endfunction

	task automatic test_reset_defaults();
		send_target(32'd0, 0);
		send_target(ONE_Q[31:0], 0);
		send_target(32'h2000_0000, 2);
	endtask

	task automatic test_bad_options();
		set_options(0, 0, 0, 0, 32);
		send_target(32'h2000_0000, 0);
		set_options(0, 0, 1024, 0, 0);
		send_target(32'h2000_0000, 1);
		// out-of-domain target must still report the option error first
		send_target(32'hFFFF_FFFF, 0);
	endtask

	task automatic test_domain();
		set_options(32'h0800_0000, 0, 1024, 0, 32);
		send_target(32'hFFFF_FFFF, 0);
		send_target(32'h8000_0000, 0);
		send_target(32'h7FFF_FFFF, 3);
		send_target(ONE_Q[31:0] + 1, 0);
		send_target(ONE_Q[31:0], 0);
	endtask

	task automatic test_nonmonotone();
		set_options(32'h8000_0000, 32'h7FFF_FFFF, 1024, 0, 32);
		send_target(32'h1000_0000, 0);
		set_options(32'h0A00_0000, 32'hFB00_0000, 1024, 32'h7FFF_FFFF, 32);
		send_target(32'h1000_0000, 0);
		set_options(32'h0A00_0000, 32'hFB00_0000, 1024, 0, 32);
		send_target(32'h1000_0000, 0);
	endtask

	task automatic test_bisection_and_limit();
		set_options(32'h1300_0000, 32'hF800_0000, 32'h7FFF_FFFF, 0, 255);
		send_target(32'h0123_4567, 0);
		set_options(32'h1300_0000, 32'hF800_0000, 1, 0, 3);
		send_target(32'h0200_0000, 0);
		send_target(32'h3F00_0000, 1);
		write_option(CFG_MAX_ITER, 1);
		send_target(32'h1555_5555, 0);
		write_option(CFG_SPARE_LO, 32'hFFFF_FFFF);
		write_option(CFG_SPARE_HI, 32'h0);
		send_target(32'h2AAA_AAAA, 0);
	endtask

	task automatic test_random_phases();
		logic [31:0] e, d, y;
		int n;
		for (int ph = 0; ph < 8; ph++) begin
			e = $urandom_range(0, 32'h1300_0000);
			d = $urandom_range(0, 32'h0900_0000);
			if ($urandom_range(0, 1)) e = -e;
			if ($urandom_range(0, 1)) d = -d;
			if (ph == 3) e = 32'h7000_0000;
			set_options(e, d,
				($urandom_range(0, 3) == 0) ? $urandom_range(1, 16) : $urandom_range(1, 1 << 20),
				($urandom_range(0, 2) == 0) ? $urandom_range(0, 32'h1000_0000) : 0,
				$urandom_range(1, 24));
			n = 90;
			for (int i = 0; i < n; i++) begin
				case ($urandom_range(0, 9))
					0: y = $urandom;
					1: y = ONE_Q[31:0] + $urandom_range(1, 32'h0FFF_FFFF);
					2: y = ($urandom_range(0, 1)) ? 32'd0 : ONE_Q[31:0];
					default: y = $urandom_range(0, ONE_Q[31:0]);
				endcase
				send_target(y, (i % 30 < 10) ? 0 : pick_gap());
				if (i == 45)
					drain_results();
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		start <= 1'b0;
		target <= '0;
		cfg_valid <= 1'b0;
		cfg_index <= '0;
		cfg_data <= '0;
		epsilon_q = 0;
		delta_q = 0;
		tolerance_q = 31'd1024;
		margin_q = 0;
		iter_limit_q = 8'd32;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		test_reset_defaults();
		test_bad_options();
		test_domain();
		test_nonmonotone();
		test_bisection_and_limit();
		test_random_phases();
		drain_results();
		repeat (20) @(posedge clk);
		if (mismatches == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule

/* files.f */
+incdir+hw/rtl
hw/rtl/swis_pkg.sv
hw/rtl/sine_warp_inverse_solver_unit.sv
tb/sine_warp_inverse_solver_unit_test.sv
